// ----- rtl/core/ral_pkg.sv -----
// ral_pkg: shared codes and constants of the resource admission ledger
// operation, status and register index codes, controller state encoding, default parameter values
// no dependencies
`default_nettype none
package ral_pkg;

   localparam int DEF_ENTRIES  = 64;
   localparam int DEF_CPU_BITS = 20;
   localparam int DEF_MEM_BITS = 24;

   localparam int CPU_TOT_W = 26;
   localparam int MEM_TOT_W = 30;
   localparam int CNT_W     = 7;
   localparam int ID_W      = 64;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 30;

   localparam logic [1:0] OP_RESERVE = 2'd0;
   localparam logic [1:0] OP_COMMIT  = 2'd1;
   localparam logic [1:0] OP_RELEASE = 2'd2;
   localparam logic [1:0] OP_USAGE   = 2'd3;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_INVALID  = 3'd1;
   localparam logic [2:0] ST_CONFLICT = 3'd2;
   localparam logic [2:0] ST_CAPACITY = 3'd3;
   localparam logic [2:0] ST_NOTFOUND = 3'd4;
   localparam logic [2:0] ST_FULL     = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_CPU_CAP = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MEM_CAP = 1'd1;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_SCAN  = 4'b0010,
      S_SWEEP = 4'b0100,
      S_DONE  = 4'b1000
   } state_type;

endpackage
`default_nettype wire

// ----- rtl/core/ral_cell.sv -----
// ral_cell: one record slot of the rotating record chain
// takes its neighbor's record whenever the chain shifts; uses ral_pkg
`default_nettype none
module ral_cell
   import ral_pkg::*;
#(
   parameter int W = 8
) (
   input  wire logic         clock,
   input  wire logic         shift,
   input  wire logic [W-1:0] rec_in,
   output logic [W-1:0]      rec_out
);

   logic [W-1:0] rec_ff;

   // payload only, no reset
   always_ff @(posedge clock) begin
      if (shift) begin
         rec_ff <= rec_in;
      end
   end

   assign rec_out = rec_ff;

endmodule
`default_nettype wire

// ----- rtl/core/resource_admission_ledger_top.sv -----
// resource_admission_ledger_top: job admission ledger over a rotating chain of record cells
// depends on ral_pkg and ral_cell
//
// channel    ports                      handshake
// request    req_op/job_id/amounts      start high while busy low
// response   rsp_* fields               rsp_valid for one cycle, no back pressure
// csr        csr_we/csr_index/csr_wdata write when csr_we high, no read-back
//
// one transaction rotates the record chain twice: once to look up the id and
// capture the last record, and once more to apply the change while summing
// totals, counts and picking the victim
// the response strobes in the last cycle; busy drops the cycle after
// reset is synchronous and clears control, totals, entry count and capacities;
// records are not cleared, only slots below the entry count are ever looked at
// the receiver cannot stall, so results are never held back
`default_nettype none
module resource_admission_ledger_top
   import ral_pkg::*;
#(
   parameter int ENTRIES  = DEF_ENTRIES,
   parameter int CPU_BITS = DEF_CPU_BITS,
   parameter int MEM_BITS = DEF_MEM_BITS
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [1:0]           req_op,
   input  wire logic [ID_W-1:0]      req_job_id,
   input  wire logic [CPU_BITS-1:0]  req_cpu_amount,
   input  wire logic [MEM_BITS-1:0]  req_mem_amount,
   output logic                      rsp_valid,
   output logic [2:0]                rsp_status,
   output logic [CPU_TOT_W-1:0]      rsp_cpu_booked,
   output logic [MEM_TOT_W-1:0]      rsp_mem_used,
   output logic [CNT_W-1:0]          rsp_running_count,
   output logic [CNT_W-1:0]          rsp_reserved_count,
   output logic                      rsp_oversubscribed,
   output logic                      rsp_victim_found,
   output logic [ID_W-1:0]           rsp_victim_id,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_wdata
);

   localparam int IDXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNTW = $clog2(ENTRIES + 1);
   localparam int CSW  = ((CPU_BITS > CPU_TOT_W) ? CPU_BITS : CPU_TOT_W) + 1;
   localparam int MSW  = ((MEM_BITS > MEM_TOT_W) ? MEM_BITS : MEM_TOT_W) + 1;
   localparam logic [IDXW-1:0] LAST_IDX = IDXW'(ENTRIES - 1);
   localparam logic [CNTW-1:0] FULL_CNT = CNTW'(ENTRIES);
   localparam logic [CPU_TOT_W-1:0] CPU_MAX = '1;
   localparam logic [MEM_TOT_W-1:0] MEM_MAX = '1;
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   typedef struct packed {
      logic [ID_W-1:0]     id;
      logic [CPU_BITS-1:0] exp_cpu;
      logic [MEM_BITS-1:0] exp_mem;
      logic [CPU_BITS-1:0] act_cpu;
      logic [MEM_BITS-1:0] act_mem;
      logic                running;
      logic                reserved;
   } rec_type;

   localparam int RW = $bits(rec_type);

   // control state
   state_type            state_ff, state_in;
   logic [IDXW-1:0]      pos_ff, pos_in;
   logic [CNTW-1:0]      count_ff, count_in;
   logic [CPU_TOT_W-1:0] cpu_total_ff, cpu_total_in;
   logic [MEM_TOT_W-1:0] mem_total_ff, mem_total_in;

   // capacity registers
   logic [CPU_TOT_W-1:0] cpu_cap_ff;
   logic [MEM_TOT_W-1:0] mem_cap_ff;

   // per transaction working registers (payload)
   logic [1:0]           op_ff;
   logic [ID_W-1:0]      id_ff;
   logic [CPU_BITS-1:0]  cpu_ff;
   logic [MEM_BITS-1:0]  mem_ff;
   logic                 found_ff, found_in;
   logic [IDXW-1:0]      hit_ff, hit_in;
   rec_type              last_ff, last_in;
   logic [2:0]           status_ff, status_in;
   logic [CNTW-1:0]      ncount_ff, ncount_in;
   logic [CPU_TOT_W-1:0] acc_cpu_ff, acc_cpu_in;
   logic [MEM_TOT_W-1:0] acc_mem_ff, acc_mem_in;
   logic [CNT_W-1:0]     run_ff, run_in;
   logic [CNT_W-1:0]     res_ff, res_in;
   logic                 vfound_ff, vfound_in;
   logic [ID_W-1:0]      vid_ff, vid_in;
   logic [MEM_BITS-1:0]  vmem_ff, vmem_in;

   // record chain, cell 0 is the head seen by the controller
   rec_type cell_q [ENTRIES];
   rec_type head, tail;
   logic    shift;

   assign head  = cell_q[0];
   assign shift = (state_ff == S_SCAN) || (state_ff == S_SWEEP);

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      rec_type nxt;
      if (g == ENTRIES - 1) begin : g_tail
         assign nxt = tail;
      end else begin : g_mid
         assign nxt = cell_q[g+1];
      end
      ral_cell #(.W(RW)) u_cell (
         .clock   (clock),
         .shift   (shift),
         .rec_in  (nxt),
         .rec_out (cell_q[g])
      );
   end

   wire accept = start && !busy;
   wire at_end = (pos_ff == LAST_IDX);
   wire in_use = (CNTW'(pos_ff) < count_ff);

   logic [CSW-1:0]      cpu_need;
   logic [MSW-1:0]      mem_need;
   logic                ok;
   rec_type             mod;
   logic [CPU_BITS-1:0] max_cpu;
   logic [MEM_BITS-1:0] max_mem;
   logic [CSW-1:0]      cpu_sum;
   logic [MSW-1:0]      mem_sum;

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      cpu_total_in = cpu_total_ff;
      mem_total_in = mem_total_ff;
      found_in     = found_ff;
      hit_in       = hit_ff;
      last_in      = last_ff;
      status_in    = status_ff;
      ncount_in    = ncount_ff;
      acc_cpu_in   = acc_cpu_ff;
      acc_mem_in   = acc_mem_ff;
      run_in       = run_ff;
      res_in       = res_ff;
      vfound_in    = vfound_ff;
      vid_in       = vid_ff;
      vmem_in      = vmem_ff;
      tail         = head;
      mod          = head;
      cpu_need     = CSW'(cpu_total_ff) + CSW'(cpu_ff);
      mem_need     = MSW'(mem_total_ff) + MSW'(mem_ff);
      ok           = (status_ff == ST_OK);

      // record as it leaves the head during the second rotation
      if (ok && found_ff && pos_ff == hit_ff) begin
         unique case (op_ff)
            OP_COMMIT: begin
               mod.running  = 1'b1;
               mod.reserved = 1'b0;
            end
            OP_RELEASE: mod = last_ff;
            OP_USAGE: begin
               mod.act_cpu = cpu_ff;
               mod.act_mem = mem_ff;
            end
            default: ;
         endcase
      end
      if (ok && op_ff == OP_RESERVE && CNTW'(pos_ff) == count_ff) begin
         mod.id       = id_ff;
         mod.exp_cpu  = cpu_ff;
         mod.exp_mem  = mem_ff;
         mod.act_cpu  = '0;
         mod.act_mem  = '0;
         mod.running  = 1'b0;
         mod.reserved = 1'b1;
      end
      max_cpu = (mod.exp_cpu > mod.act_cpu) ? mod.exp_cpu : mod.act_cpu;
      max_mem = (mod.exp_mem > mod.act_mem) ? mod.exp_mem : mod.act_mem;
      cpu_sum = CSW'(acc_cpu_ff) + CSW'(max_cpu);
      mem_sum = MSW'(acc_mem_ff) + MSW'(max_mem);

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_SCAN;
               pos_in   = '0;
               found_in = 1'b0;
            end
         end
         S_SCAN: begin
            // first rotation: id lookup and capture of the last record
            if (in_use && !found_ff && head.id == id_ff) begin
               found_in = 1'b1;
               hit_in   = pos_ff;
            end
            if (count_ff != '0 && CNTW'(pos_ff) == count_ff - 1'b1) begin
               last_in = head;
            end
            pos_in = pos_ff + 1'b1;
            if (at_end) begin
               priority if (op_ff == OP_RESERVE) begin
                  priority if (id_ff == '0 || cpu_ff == '0 || mem_ff == '0) begin
                     status_in = ST_INVALID;
                  end else if (found_in) begin
                     status_in = ST_CONFLICT;
                  end else if (cpu_need > CSW'(cpu_cap_ff) ||
                               mem_need > MSW'(mem_cap_ff)) begin
                     status_in = ST_CAPACITY;
                  end else if (count_ff == FULL_CNT) begin
                     status_in = ST_FULL;
                  end else begin
                     status_in = ST_OK;
                  end
               end else begin
                  status_in = found_in ? ST_OK : ST_NOTFOUND;
               end
               ncount_in = count_ff;
               if (status_in == ST_OK && op_ff == OP_RESERVE) begin
                  ncount_in = count_ff + 1'b1;
               end else if (status_in == ST_OK && op_ff == OP_RELEASE) begin
                  ncount_in = count_ff - 1'b1;
               end
               pos_in     = '0;
               acc_cpu_in = '0;
               acc_mem_in = '0;
               run_in     = '0;
               res_in     = '0;
               vfound_in  = 1'b0;
               vid_in     = '0;
               vmem_in    = '0;
               state_in   = S_SWEEP;
            end
         end
         S_SWEEP: begin
            // second rotation: apply the change, sum totals, counts, victim
            tail = mod;
            if (CNTW'(pos_ff) < ncount_ff) begin
               acc_cpu_in = (cpu_sum > CSW'(CPU_MAX)) ? CPU_MAX : cpu_sum[CPU_TOT_W-1:0];
               acc_mem_in = (mem_sum > MSW'(MEM_MAX)) ? MEM_MAX : mem_sum[MEM_TOT_W-1:0];
               if (mod.running) begin
                  if (run_ff != CNT_MAX) begin
                     run_in = run_ff + 1'b1;
                  end
                  if (!vfound_ff || mod.act_mem > vmem_ff) begin
                     vfound_in = 1'b1;
                     vid_in    = mod.id;
                     vmem_in   = mod.act_mem;
                  end
               end
               if (mod.reserved && res_ff != CNT_MAX) begin
                  res_in = res_ff + 1'b1;
               end
            end
            pos_in = pos_ff + 1'b1;
            if (at_end) begin
               count_in     = ncount_ff;
               cpu_total_in = acc_cpu_in;
               mem_total_in = acc_mem_in;
               state_in     = S_DONE;
            end
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pos_ff       <= '0;
         count_ff     <= '0;
         cpu_total_ff <= '0;
         mem_total_ff <= '0;
         cpu_cap_ff   <= '0;
         mem_cap_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         count_ff     <= count_in;
         cpu_total_ff <= cpu_total_in;
         mem_total_ff <= mem_total_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_CPU_CAP: cpu_cap_ff <= csr_wdata[CPU_TOT_W-1:0];
               CSR_MEM_CAP: mem_cap_ff <= csr_wdata[MEM_TOT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // working registers, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_op;
         id_ff  <= req_job_id;
         cpu_ff <= req_cpu_amount;
         mem_ff <= req_mem_amount;
      end
      found_ff  <= found_in;
      hit_ff    <= hit_in;
      last_ff   <= last_in;
      status_ff <= status_in;
      ncount_ff <= ncount_in;
      acc_cpu_ff <= acc_cpu_in;
      acc_mem_ff <= acc_mem_in;
      run_ff    <= run_in;
      res_ff    <= res_in;
      vfound_ff <= vfound_in;
      vid_ff    <= vid_in;
      vmem_ff   <= vmem_in;
   end

   // response ports, shown during the single done cycle
   assign busy               = (state_ff != S_IDLE);
   assign rsp_valid          = (state_ff == S_DONE);
   assign rsp_status         = status_ff;
   assign rsp_cpu_booked     = cpu_total_ff;
   assign rsp_mem_used       = mem_total_ff;
   assign rsp_running_count  = run_ff;
   assign rsp_reserved_count = res_ff;
   assign rsp_oversubscribed = (cpu_total_ff > cpu_cap_ff) || (mem_total_ff > mem_cap_ff);
   assign rsp_victim_found   = vfound_ff;
   assign rsp_victim_id      = vid_ff;

   // checks
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy) else $error("busy not raised after accepted transaction");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy) else $error("busy held after response");

   a_no_victim_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_victim_found) |-> (rsp_victim_id == '0))
      else $error("victim id not zero without a running record");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= ST_FULL)) else $error("status code out of range");

endmodule
`default_nettype wire

// ----- test/testbench.sv -----
// testbench: self-checking bench for resource_admission_ledger_top
// keeps its own ledger copy to predict every response; depends on ral_pkg and the rtl
`timescale 1ns / 100ps
module testbench
   import ral_pkg::*;
();

   localparam int SLOTS = DEF_ENTRIES;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int ID_POOL = 96;

   typedef struct {
      logic [1:0]  op;
      logic [63:0] id;
      logic [19:0] cpu;
      logic [23:0] mem;
   } ledger_req_type;

   typedef struct packed {
      logic [2:0]           status;
      logic [CPU_TOT_W-1:0] cpu_booked;
      logic [MEM_TOT_W-1:0] mem_used;
      logic [CNT_W-1:0]     running;
      logic [CNT_W-1:0]     reserved;
      logic                 oversub;
      logic                 vfound;
      logic [63:0]          vid;
   } ledger_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0]  req_op = '0;
   logic [63:0] req_job_id = '0;
   logic [19:0] req_cpu_amount = '0;
   logic [23:0] req_mem_amount = '0;
   logic rsp_valid;
   logic [2:0] rsp_status;
   logic [CPU_TOT_W-1:0] rsp_cpu_booked;
   logic [MEM_TOT_W-1:0] rsp_mem_used;
   logic [CNT_W-1:0] rsp_running_count, rsp_reserved_count;
   logic rsp_oversubscribed, rsp_victim_found;
   logic [63:0] rsp_victim_id;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   resource_admission_ledger_top dut (.*);

   always #5 clock = ~clock;

   // shadow ledger
   logic [63:0] led_id [SLOTS];
   logic [19:0] led_exp_cpu [SLOTS], led_act_cpu [SLOTS];
   logic [23:0] led_exp_mem [SLOTS], led_act_mem [SLOTS];
   logic        led_run [SLOTS], led_resv [SLOTS];
   int          led_count = 0;
   longint unsigned cpu_sum = 0, mem_sum = 0;
   longint unsigned cpu_cap = 0, mem_cap = 0;

   ledger_req_type pending_reqs[$];
   ledger_rsp_type expected_rsps[$];
   ledger_req_type cur_req;
   logic [63:0] id_pool [ID_POOL];
   int gap_pct = 0;
   int errors = 0;
   int cycles = 0;

   function automatic int find_slot(logic [63:0] id);
      for (int i = 0; i < led_count; i++)
         if (led_id[i] == id) return i;
      return -1;
   endfunction

   function automatic void resum();
      longint unsigned c = 0, m = 0;
      for (int i = 0; i < led_count; i++) begin
         c += (led_exp_cpu[i] > led_act_cpu[i]) ? led_exp_cpu[i] : led_act_cpu[i];
         m += (led_exp_mem[i] > led_act_mem[i]) ? led_exp_mem[i] : led_act_mem[i];
      end
      cpu_sum = (c > 64'h3FFFFFF) ? 64'h3FFFFFF : c;
      mem_sum = (m > 64'h3FFFFFFF) ? 64'h3FFFFFFF : m;
   endfunction

   // apply one request to the shadow ledger and queue the response it should give
   function automatic void ledger_apply(ledger_req_type r);
      ledger_rsp_type e;
      int k;
      int last;
      logic [23:0] vmem = '0;
      e = '0;
      e.status = ST_NOTFOUND;
      if (r.op == OP_RESERVE) begin
         if (r.id == 0 || r.cpu == 0 || r.mem == 0) e.status = ST_INVALID;
         else if (find_slot(r.id) >= 0) e.status = ST_CONFLICT;
         else if (cpu_sum + r.cpu > cpu_cap || mem_sum + r.mem > mem_cap)
            e.status = ST_CAPACITY;
         else if (led_count >= SLOTS) e.status = ST_FULL;
         else begin
            led_id[led_count] = r.id;
            led_exp_cpu[led_count] = r.cpu;
            led_exp_mem[led_count] = r.mem;
            led_act_cpu[led_count] = '0;
            led_act_mem[led_count] = '0;
            led_run[led_count] = 1'b0;
            led_resv[led_count] = 1'b1;
            led_count++;
            resum();
            e.status = ST_OK;
         end
      end else begin
         k = find_slot(r.id);
         if (k >= 0) begin
            e.status = ST_OK;
            if (r.op == OP_COMMIT) begin
               led_run[k] = 1'b1;
               led_resv[k] = 1'b0;
            end else if (r.op == OP_RELEASE) begin
               last = led_count - 1;
               led_id[k] = led_id[last];
               led_exp_cpu[k] = led_exp_cpu[last];
               led_exp_mem[k] = led_exp_mem[last];
               led_act_cpu[k] = led_act_cpu[last];
               led_act_mem[k] = led_act_mem[last];
               led_run[k] = led_run[last];
               led_resv[k] = led_resv[last];
               led_count = last;
            end else begin
               led_act_cpu[k] = r.cpu;
               led_act_mem[k] = r.mem;
            end
            resum();
         end
      end
      for (int i = 0; i < led_count; i++) begin
         if (led_run[i]) begin
            e.running++;
            // running record with the largest actual memory wins, the first one on a tie
            if (!e.vfound || led_act_mem[i] > vmem) begin
               e.vfound = 1'b1;
               e.vid = led_id[i];
               vmem = led_act_mem[i];
            end
         end
         if (led_resv[i]) e.reserved++;
      end
      e.cpu_booked = CPU_TOT_W'(cpu_sum);
      e.mem_used = MEM_TOT_W'(mem_sum);
      e.oversub = (cpu_sum > cpu_cap) || (mem_sum > mem_cap);
      expected_rsps.push_back(e);
   endfunction

   // request driver: offers the next queued transaction with random gaps
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) ledger_apply(cur_req);
         if (!start || !busy) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= gap_pct) begin
               cur_req = pending_reqs.pop_front();
               req_op <= cur_req.op;
               req_job_id <= cur_req.id;
               req_cpu_amount <= cur_req.cpu;
               req_mem_amount <= cur_req.mem;
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t mismatch %s: expected %0h actual %0h", $time, name, exp_v, act_v);
         errors++;
      end
   endfunction

   // response monitor: every strobe is matched against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t unexpected response: expected none actual status %0d",
                     $time, rsp_status);
            errors++;
         end else begin
            automatic ledger_rsp_type e = expected_rsps.pop_front();
            check_field("status", e.status, rsp_status);
            check_field("cpu_booked", e.cpu_booked, rsp_cpu_booked);
            check_field("mem_used", e.mem_used, rsp_mem_used);
            check_field("running_count", e.running, rsp_running_count);
            check_field("reserved_count", e.reserved, rsp_reserved_count);
            check_field("oversubscribed", e.oversub, rsp_oversubscribed);
            check_field("victim_found", e.vfound, rsp_victim_found);
            check_field("victim_id", e.vid, rsp_victim_id);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic push_req(logic [1:0] op, logic [63:0] id, logic [19:0] cpu, logic [23:0] mem);
      ledger_req_type r;
      r.op = op;
      r.id = id;
      r.cpu = cpu;
      r.mem = mem;
      pending_reqs.push_back(r);
   endtask

   // sender holds off until every transaction has been answered
   task automatic wait_idle();
      wait (pending_reqs.size() == 0);
      do begin
         @(posedge clock);
         #1;
      end while (start || busy || expected_rsps.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_CPU_CAP) cpu_cap = val[CPU_TOT_W-1:0];
      else mem_cap = val;
   endtask

   // mostly well-formed traffic on a pool of ids, a little noise
   task automatic push_random(int n, int reserve_w, bit big_amounts);
      logic [63:0] id;
      logic [1:0] op;
      logic [19:0] cpu;
      logic [23:0] mem;
      int pick;
      repeat (n) begin
         pick = $urandom_range(99);
         if (pick < reserve_w) op = OP_RESERVE;
         else if (pick < reserve_w + 25) op = OP_COMMIT;
         else if (pick < reserve_w + 45) op = OP_USAGE;
         else op = OP_RELEASE;
         pick = $urandom_range(99);
         if (pick < 3) id = '0;
         else if (pick < 6) id = {$urandom, $urandom};
         else id = id_pool[$urandom_range(ID_POOL - 1)];
         if (big_amounts || $urandom_range(9) == 0) begin
            cpu = 20'($urandom);
            mem = 24'($urandom);
         end else begin
            cpu = 20'($urandom_range(4095));
            mem = 24'($urandom_range(4095));
         end
         if ($urandom_range(49) == 0) cpu = '0;
         if ($urandom_range(49) == 0) mem = '0;
         push_req(op, id, cpu, mem);
      end
   endtask

   initial begin
      for (int i = 0; i < ID_POOL; i++) id_pool[i] = {$urandom, $urandom} | 64'd1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset capacities are zero: every valid reserve runs out of room
      push_req(OP_RESERVE, 64'd5, 20'd1, 24'd1);
      push_req(OP_RESERVE, 64'd0, 20'd1, 24'd1);
      push_req(OP_RESERVE, 64'd7, 20'd0, 24'd1);
      push_req(OP_RESERVE, 64'd7, 20'd1, 24'd0);
      push_req(OP_COMMIT, 64'd0, 20'd0, 24'd0);
      push_req(OP_RELEASE, 64'd9, 20'd0, 24'd0);
      push_req(OP_USAGE, 64'd9, 20'hFFFFF, 24'hFFFFFF);
      wait_idle();

      csr_write(CSR_CPU_CAP, 30'h3FFFFFF);
      csr_write(CSR_MEM_CAP, 30'h3FFFFFFF);
      push_req(OP_RESERVE, 64'hFFFF_FFFF_FFFF_FFFF, 20'hFFFFF, 24'hFFFFFF);
      push_req(OP_RESERVE, 64'hFFFF_FFFF_FFFF_FFFF, 20'd1, 24'd1);
      push_req(OP_RESERVE, 64'h1, 20'd1, 24'd1);
      push_req(OP_COMMIT, 64'h1, 20'd0, 24'd0);
      push_req(OP_COMMIT, 64'hFFFF_FFFF_FFFF_FFFF, 20'd0, 24'd0);
      push_req(OP_USAGE, 64'h1, 20'hFFFFF, 24'hFFFFFF);
      push_req(OP_USAGE, 64'hFFFF_FFFF_FFFF_FFFF, 20'd0, 24'hFFFFFF);
      push_req(OP_RELEASE, 64'h1, 20'd0, 24'd0);
      push_req(OP_RELEASE, 64'h1, 20'd0, 24'd0);
      push_req(OP_RELEASE, 64'hFFFF_FFFF_FFFF_FFFF, 20'd0, 24'd0);
      push_req(OP_COMMIT, 64'h1, 20'd0, 24'd0);
      wait_idle();

      // roomy capacities: the table fills up and table full shows up
      gap_pct = 16;
      push_random(700, 55, 1'b0);
      push_random(60, 20, 1'b1);
      wait_idle();

      // tight capacities: capacity exhausted and oversubscription
      csr_write(CSR_CPU_CAP, CSR_DAT_W'($urandom_range(20000, 60000)));
      csr_write(CSR_MEM_CAP, CSR_DAT_W'($urandom_range(20000, 60000)));
      gap_pct = 48;
      push_random(600, 45, 1'b0);
      wait_idle();

      csr_write(CSR_CPU_CAP, 30'h3FFFFFF);
      csr_write(CSR_MEM_CAP, 30'd0);
      gap_pct = 0;
      push_random(100, 40, 1'b0);
      wait_idle();
      csr_write(CSR_MEM_CAP, 30'h3FFFFFFF);
      push_random(500, 45, 1'b0);
      wait_idle();

      repeat (150) @(posedge clock);
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
